// ===== src/hns_pkg.sv =====
// ---------------------------------------------------------------------------
// Height normal shader package
// Widths, register codes and the item carried through the root and divide
// pipelines of the height normal shader.
// ---------------------------------------------------------------------------
`default_nettype none

package hns_pkg;

   localparam int PIX_W     = 8;
   localparam int COORD_W   = 40;
   localparam int HDIFF_W   = 33;
   localparam int CPROD_W   = 62;
   localparam int RAW_W     = 64;
   localparam int DET_W     = 108;
   localparam int MAG_W     = 107;
   localparam int NORM_BITS = 30;
   localparam int GRP_W     = 16;
   localparam int GROUPS    = 7;
   localparam int SCAN_W    = GROUPS * GRP_W;
   localparam int LEN_W     = 5;
   localparam int SHIFT_W   = 7;
   localparam int WIDE_W    = MAG_W + NORM_BITS;
   localparam int COARSE_W  = NORM_BITS + GRP_W - 1;
   localparam int SQ_W      = 2 * NORM_BITS;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ISQ_W     = 64;
   localparam int ISQ_STEPS = 32;
   localparam int ROOT_W    = 31;
   localparam int QUO_W     = 16;
   localparam int REM_W     = NORM_BITS + QUO_W;
   localparam int T_W       = 16;
   localparam int BLEND_W   = 25;

   localparam logic [T_W-1:0] T_HALF = 16'h8000;
   localparam logic [T_W-1:0] T_MAX  = 16'hFFFF;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_STEP_X     = 3'd2,
      CSR_STEP_Y     = 3'd3,
      CSR_COMP_SEL   = 3'd4,
      CSR_LOW_COLOR  = 3'd5,
      CSR_HIGH_COLOR = 3'd6
   } csr_index_type;

   localparam logic signed [31:0] ORIGIN_RESET = -32'sd655360;
   localparam logic [30:0] STEP_RESET       = 31'd6554;
   localparam logic [1:0]  COMP_SEL_RESET   = 2'd0;
   localparam logic [31:0] LOW_COLOR_RESET  = 32'hFF000000;
   localparam logic [31:0] HIGH_COLOR_RESET = 32'hFFFFFFFF;

   typedef struct packed {
      logic [PIX_W-1:0]     x;
      logic [PIX_W-1:0]     y;
      logic [NORM_BITS-1:0] mag;
      logic                 neg;
      logic                 zero;
   } side_type;

endpackage

`default_nettype wire

// ===== src/hns_isqrt.sv =====
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Takes the floor square root of the sum of squares, one result bit per
// register stage, carrying the pixel side data alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module hns_isqrt
   import hns_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   logic             vld_ff  [ISQ_STEPS+1];
   logic [ISQ_W-1:0] rem_ff  [ISQ_STEPS+1];
   logic [ISQ_W-1:0] res_ff  [ISQ_STEPS+1];
   side_type         side_ff [ISQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= ISQ_W'(in_sum);
         res_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
      localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
      logic [ISQ_W-1:0] trial_in;
      assign trial_in = res_ff[k] + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k+1] <= side_ff[k];
            if (rem_ff[k] >= trial_in) begin
               rem_ff[k+1] <= rem_ff[k] - trial_in;
               res_ff[k+1] <= (res_ff[k] >> 1) + BIT;
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               res_ff[k+1] <= res_ff[k] >> 1;
            end
         end
      end
   end

   assign out_valid = vld_ff[ISQ_STEPS];
   assign out_root  = res_ff[ISQ_STEPS][ROOT_W-1:0];
   assign out_side  = side_ff[ISQ_STEPS];

endmodule

`default_nettype wire

// ===== src/hns_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined normal component divider
// Divides the selected magnitude, scaled to Q1.15, by the norm, one quotient
// bit per register stage, carrying the pixel side data alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module hns_div
   import hns_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_root,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output side_type          out_side
);

   logic              vld_ff  [QUO_W+1];
   logic [REM_W-1:0]  rem_ff  [QUO_W+1];
   logic [ROOT_W-1:0] div_ff  [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff  [QUO_W+1];
   side_type          side_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= REM_W'({in_side.mag, 15'b0});
         div_ff[0]  <= in_root;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      logic [REM_W-1:0] dsh_in;
      assign dsh_in = REM_W'(div_ff[j]) << (QUO_W - 1 - j);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[j+1] <= vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[j+1] <= side_ff[j];
            div_ff[j+1]  <= div_ff[j];
            if (rem_ff[j] >= dsh_in) begin
               rem_ff[j+1] <= rem_ff[j] - dsh_in;
               quo_ff[j+1] <= quo_ff[j] | (QUO_W'(1) << (QUO_W - 1 - j));
            end else begin
               rem_ff[j+1] <= rem_ff[j];
               quo_ff[j+1] <= quo_ff[j];
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

`default_nettype wire

// ===== src/height_normal_shader_unit.sv =====
// ---------------------------------------------------------------------------
// Height normal shader unit
// Shades one pixel per transfer from the normal of a height surface.
// ---------------------------------------------------------------------------
// The req channel carries one pixel: its indices and three heights (here,
// one step right, one step down). The rsp channel returns the indices and the
// blended RGBA colour, one result per pixel, in order. The csr channel writes
// the plane window, the shown component and the two colours; it is always
// ready and is to be written only while no pixel is in flight.
// The work runs through thirteen arithmetic stages, a 33-stage square root, a
// 17-stage divider and two blend stages, so one pixel is taken in every cycle
// unless the receiver stalls a waiting result.
// Reset clears all valid bits and loads the default registers; no pixel is
// in flight afterwards.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module height_normal_shader_unit
   import hns_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIX_W-1:0]        req_pixel_x,
   input  logic [PIX_W-1:0]        req_pixel_y,
   input  logic signed [31:0]      req_height_here,
   input  logic signed [31:0]      req_height_right,
   input  logic signed [31:0]      req_height_below,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIX_W-1:0]        rsp_out_x,
   output logic [PIX_W-1:0]        rsp_out_y,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic [7:0]              rsp_alpha,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_wdata
);

   typedef struct packed {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
   } pix_type;

   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [30:0]        step_x_ff, step_y_ff;
   logic [1:0]         comp_sel_ff;
   logic [31:0]        low_color_ff, high_color_ff;

   logic adv;
   logic rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= ORIGIN_RESET;
         origin_y_ff   <= ORIGIN_RESET;
         step_x_ff     <= STEP_RESET;
         step_y_ff     <= STEP_RESET;
         comp_sel_ff   <= COMP_SEL_RESET;
         low_color_ff  <= LOW_COLOR_RESET;
         high_color_ff <= HIGH_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata;
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata;
            CSR_STEP_X:     step_x_ff     <= csr_wdata[30:0];
            CSR_STEP_Y:     step_y_ff     <= csr_wdata[30:0];
            CSR_COMP_SEL:   comp_sel_ff   <= csr_wdata[1:0];
            CSR_LOW_COLOR:  low_color_ff  <= csr_wdata;
            CSR_HIGH_COLOR: high_color_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Valid bits of the arithmetic stages one to thirteen.
   logic [13:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[12:1], req_valid};
      end
   end

   // Stage 1: plane coordinates, height differences and step product.
   logic [COORD_W-2:0]        s1_pxs_in, s1_pys_in;
   logic signed [COORD_W-1:0] s1_x_in, s1_y_in;
   logic signed [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic signed [HDIFF_W-1:0] s1_dr_ff, s1_db_ff;
   logic [CPROD_W-1:0]        s1_c_ff;
   logic signed [31:0]        s1_zh_ff;
   pix_type                   s1_pix_ff;

   assign s1_pxs_in = (COORD_W-1)'(req_pixel_x) * (COORD_W-1)'(step_x_ff);
   assign s1_pys_in = (COORD_W-1)'(req_pixel_y) * (COORD_W-1)'(step_y_ff);
   assign s1_x_in   = COORD_W'(origin_x_ff) + $signed({1'b0, s1_pxs_in});
   assign s1_y_in   = COORD_W'(origin_y_ff) + $signed({1'b0, s1_pys_in});

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff   <= s1_x_in;
         s1_y_ff   <= s1_y_in;
         s1_dr_ff  <= HDIFF_W'(req_height_right) - HDIFF_W'(req_height_here);
         s1_db_ff  <= HDIFF_W'(req_height_below) - HDIFF_W'(req_height_here);
         s1_c_ff   <= CPROD_W'(step_x_ff) * CPROD_W'(step_y_ff);
         s1_zh_ff  <= req_height_here;
         s1_pix_ff <= '{x: req_pixel_x, y: req_pixel_y};
      end
   end

   // Stage 2: the raw determinants A and B before scaling.
   logic signed [RAW_W:0]     s2_pa_in, s2_na_in, s2_pb_in;
   logic signed [RAW_W-1:0]   s2_a_ff, s2_b_ff;
   logic signed [COORD_W-1:0] s2_x_ff, s2_y_ff;
   logic [CPROD_W-1:0]        s2_c_ff;
   logic signed [31:0]        s2_zh_ff;
   pix_type                   s2_pix_ff;

   assign s2_pa_in = $signed({1'b0, step_y_ff}) * s1_dr_ff;
   assign s2_na_in = -s2_pa_in;
   assign s2_pb_in = $signed({1'b0, step_x_ff}) * s1_db_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_a_ff   <= s2_na_in[RAW_W-1:0];
         s2_b_ff   <= s2_pb_in[RAW_W-1:0];
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_c_ff   <= s1_c_ff;
         s2_zh_ff  <= s1_zh_ff;
         s2_pix_ff <= s1_pix_ff;
      end
   end

   // Stage 3: partial products of the determinant D.
   logic signed [72:0]      s3_pa_lo_ff, s3_pb_lo_ff;
   logic signed [71:0]      s3_pa_hi_ff, s3_pb_hi_ff;
   logic signed [63:0]      s3_pc_lo_ff, s3_pc_hi_ff;
   logic signed [RAW_W-1:0] s3_a_ff, s3_b_ff;
   logic [CPROD_W-1:0]      s3_c_ff;
   pix_type                 s3_pix_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_pa_lo_ff <= s2_x_ff * $signed({1'b0, s2_a_ff[31:0]});
         s3_pa_hi_ff <= s2_x_ff * $signed(s2_a_ff[63:32]);
         s3_pb_lo_ff <= s2_y_ff * $signed({1'b0, s2_b_ff[31:0]});
         s3_pb_hi_ff <= s2_y_ff * $signed(s2_b_ff[63:32]);
         s3_pc_lo_ff <= s2_zh_ff * $signed({1'b0, s2_c_ff[30:0]});
         s3_pc_hi_ff <= s2_zh_ff * $signed({1'b0, s2_c_ff[61:31]});
         s3_a_ff     <= s2_a_ff;
         s3_b_ff     <= s2_b_ff;
         s3_c_ff     <= s2_c_ff;
         s3_pix_ff   <= s2_pix_ff;
      end
   end

   // Stage 4: the three full products of D.
   logic signed [DET_W-1:0] s4_ta_ff, s4_tb_ff, s4_tc_ff;
   logic signed [RAW_W-1:0] s4_a_ff, s4_b_ff;
   logic [CPROD_W-1:0]      s4_c_ff;
   pix_type                 s4_pix_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ta_ff  <= (DET_W'(s3_pa_hi_ff) <<< 32) + DET_W'(s3_pa_lo_ff);
         s4_tb_ff  <= (DET_W'(s3_pb_hi_ff) <<< 32) + DET_W'(s3_pb_lo_ff);
         s4_tc_ff  <= (DET_W'(s3_pc_hi_ff) <<< 31) + DET_W'(s3_pc_lo_ff);
         s4_a_ff   <= s3_a_ff;
         s4_b_ff   <= s3_b_ff;
         s4_c_ff   <= s3_c_ff;
         s4_pix_ff <= s3_pix_ff;
      end
   end

   // Stage 5: the four determinants at the common scale.
   logic signed [DET_W-1:0] s5_det_ff [4];
   pix_type                 s5_pix_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_det_ff[0] <= DET_W'(s4_a_ff) <<< 16;
         s5_det_ff[1] <= DET_W'(s4_b_ff) <<< 16;
         s5_det_ff[2] <= DET_W'({s4_c_ff, 16'b0});
         s5_det_ff[3] <= s4_ta_ff - s4_tb_ff + s4_tc_ff;
         s5_pix_ff    <= s4_pix_ff;
      end
   end

   // Stage 6: signs and magnitudes.
   logic [MAG_W-1:0] s6_mag_in [4];
   logic [MAG_W-1:0] s6_mag_ff [4];
   logic [3:0]       s6_neg_ff;
   pix_type          s6_pix_ff;

   always_comb begin
      logic signed [DET_W-1:0] absv;
      for (int i = 0; i < 4; i++) begin
         absv         = s5_det_ff[i][DET_W-1] ? -s5_det_ff[i] : s5_det_ff[i];
         s6_mag_in[i] = absv[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_mag_ff <= s6_mag_in;
         for (int i = 0; i < 4; i++) begin
            s6_neg_ff[i] <= s5_det_ff[i][DET_W-1];
         end
         s6_pix_ff <= s5_pix_ff;
      end
   end

   // Stage 7: leading one within each group of the combined magnitudes.
   logic [GROUPS-1:0] s7_nz_in;
   logic [LEN_W-1:0]  s7_len_in [GROUPS];
   logic [GROUPS-1:0] s7_nz_ff;
   logic [LEN_W-1:0]  s7_len_ff [GROUPS];
   logic [MAG_W-1:0]  s7_mag_ff [4];
   logic [3:0]        s7_neg_ff;
   pix_type           s7_pix_ff;

   always_comb begin
      logic [SCAN_W-1:0] orv;
      logic [GRP_W-1:0]  grp;
      orv = SCAN_W'(s6_mag_ff[0] | s6_mag_ff[1] | s6_mag_ff[2] | s6_mag_ff[3]);
      for (int g = 0; g < GROUPS; g++) begin
         grp          = orv[g*GRP_W +: GRP_W];
         s7_nz_in[g]  = |grp;
         s7_len_in[g] = '0;
         for (int b = 0; b < GRP_W; b++) begin
            if (grp[b]) begin
               s7_len_in[g] = LEN_W'(b + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_nz_ff  <= s7_nz_in;
         s7_len_ff <= s7_len_in;
         s7_mag_ff <= s6_mag_ff;
         s7_neg_ff <= s6_neg_ff;
         s7_pix_ff <= s6_pix_ff;
      end
   end

   // Stage 8: largest bit length over all four magnitudes.
   logic [SHIFT_W-1:0] s8_m_in;
   logic [SHIFT_W-1:0] s8_m_ff;
   logic               s8_zero_ff;
   logic [MAG_W-1:0]   s8_mag_ff [4];
   logic [3:0]         s8_neg_ff;
   pix_type            s8_pix_ff;

   always_comb begin
      s8_m_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (s7_nz_ff[g]) begin
            s8_m_in = SHIFT_W'(g * GRP_W) + SHIFT_W'(s7_len_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_m_ff    <= s8_m_in;
         s8_zero_ff <= ~|s7_nz_ff;
         s8_mag_ff  <= s7_mag_ff;
         s8_neg_ff  <= s7_neg_ff;
         s8_pix_ff  <= s7_pix_ff;
      end
   end

   // Stage 9: coarse normalising shift in whole groups.
   logic [COARSE_W-1:0] s9_w_in [4];
   logic [COARSE_W-1:0] s9_w_ff [4];
   logic [3:0]          s9_mlo_ff;
   logic                s9_zero_ff;
   logic [3:0]          s9_neg_ff;
   pix_type             s9_pix_ff;

   always_comb begin
      logic [WIDE_W-1:0] wide;
      for (int i = 0; i < 4; i++) begin
         wide       = {s8_mag_ff[i], NORM_BITS'(0)} >> {s8_m_ff[6:4], 4'b0};
         s9_w_in[i] = wide[COARSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_w_ff    <= s9_w_in;
         s9_mlo_ff  <= s8_m_ff[3:0];
         s9_zero_ff <= s8_zero_ff;
         s9_neg_ff  <= s8_neg_ff;
         s9_pix_ff  <= s8_pix_ff;
      end
   end

   // Stage 10: fine normalising shift to the thirty-bit magnitudes.
   logic [NORM_BITS-1:0] s10_mag_in [4];
   logic [NORM_BITS-1:0] s10_mag_ff [4];
   logic                 s10_zero_ff;
   logic [3:0]           s10_neg_ff;
   pix_type              s10_pix_ff;

   always_comb begin
      logic [COARSE_W-1:0] fine;
      for (int i = 0; i < 4; i++) begin
         fine          = s9_w_ff[i] >> s9_mlo_ff;
         s10_mag_in[i] = fine[NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_mag_ff  <= s10_mag_in;
         s10_zero_ff <= s9_zero_ff;
         s10_neg_ff  <= s9_neg_ff;
         s10_pix_ff  <= s9_pix_ff;
      end
   end

   // Stage 11: squares and the selected component.
   logic [SQ_W-1:0]      s11_sq_ff [4];
   logic [NORM_BITS-1:0] s11_vmag_ff;
   logic                 s11_vneg_ff;
   logic                 s11_zero_ff;
   pix_type              s11_pix_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            s11_sq_ff[i] <= SQ_W'(s10_mag_ff[i]) * SQ_W'(s10_mag_ff[i]);
         end
         s11_vmag_ff <= s10_mag_ff[comp_sel_ff];
         s11_vneg_ff <= s10_neg_ff[comp_sel_ff];
         s11_zero_ff <= s10_zero_ff;
         s11_pix_ff  <= s10_pix_ff;
      end
   end

   // Stages 12 and 13: sum of the squares.
   logic [SQ_W:0]        s12_sa_ff, s12_sb_ff;
   logic [NORM_BITS-1:0] s12_vmag_ff;
   logic                 s12_vneg_ff;
   logic                 s12_zero_ff;
   pix_type              s12_pix_ff;
   logic [SUM_W-1:0]     s13_sum_ff;
   side_type             s13_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s12_sa_ff   <= (SQ_W+1)'(s11_sq_ff[0]) + (SQ_W+1)'(s11_sq_ff[1]);
         s12_sb_ff   <= (SQ_W+1)'(s11_sq_ff[2]) + (SQ_W+1)'(s11_sq_ff[3]);
         s12_vmag_ff <= s11_vmag_ff;
         s12_vneg_ff <= s11_vneg_ff;
         s12_zero_ff <= s11_zero_ff;
         s12_pix_ff  <= s11_pix_ff;
         s13_sum_ff  <= SUM_W'(s12_sa_ff) + SUM_W'(s12_sb_ff);
         s13_side_ff <= '{x: s12_pix_ff.x, y: s12_pix_ff.y, mag: s12_vmag_ff,
                          neg: s12_vneg_ff, zero: s12_zero_ff};
      end
   end

   logic              isq_valid;
   logic [ROOT_W-1:0] isq_root;
   side_type          isq_side;

   hns_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_ff[13]),
      .in_sum    (s13_sum_ff),
      .in_side   (s13_side_ff),
      .out_valid (isq_valid),
      .out_root  (isq_root),
      .out_side  (isq_side)
   );

   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   side_type         div_side;

   hns_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (isq_valid),
      .in_root   (isq_root),
      .in_side   (isq_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // Blend factor from the signed, saturated component.
   logic [T_W-1:0] t_in;
   logic [T_W-1:0] t_ff;
   logic           t_valid_ff;
   pix_type        t_pix_ff;

   always_comb begin
      priority if (div_side.zero) begin
         t_in = T_HALF;
      end else if (div_side.neg) begin
         t_in = T_HALF - div_quo;
      end else if (div_quo >= T_HALF) begin
         t_in = T_MAX;
      end else begin
         t_in = T_HALF + div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (adv) begin
         t_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff     <= t_in;
         t_pix_ff <= '{x: div_side.x, y: div_side.y};
      end
   end

   // Output register: per-channel blend, truncated.
   logic [7:0] ch_in [4];
   logic [7:0] ch_ff [4];
   pix_type    out_pix_ff;

   always_comb begin
      logic [BLEND_W-1:0] acc;
      for (int i = 0; i < 4; i++) begin
         acc = BLEND_W'(low_color_ff[8*i +: 8]) * BLEND_W'(17'h10000 - 17'(t_ff))
             + BLEND_W'(high_color_ff[8*i +: 8]) * BLEND_W'(t_ff);
         ch_in[i] = acc[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ch_ff      <= ch_in;
         out_pix_ff <= t_pix_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_pix_ff.x;
   assign rsp_out_y = out_pix_ff.y;
   assign rsp_red   = ch_ff[0];
   assign rsp_green = ch_ff[1];
   assign rsp_blue  = ch_ff[2];
   assign rsp_alpha = ch_ff[3];

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid straight after reset.");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      isq_valid |-> (isq_root >= ROOT_W'(isq_side.mag)))
      else $error("Norm below the selected component magnitude.");

   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (div_valid && !div_side.zero) |-> (div_quo <= T_HALF))
      else $error("Normal component quotient beyond one.");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// Height normal shader unit testbench
// Streams pixels with their three heights into the shader. A local model
// computes the plane determinants, the normalised component and the colour
// blend, and each rsp transfer is checked against the oldest prediction.
// Directed pixels cover the field extremes, every component and the zero norm
// case. Random phases follow, each with its own register setting and idling
// mix on both channels.
// ---------------------------------------------------------------------------
module tb;
   import hns_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;

   typedef struct {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] ch [4];
   } shaded_pixel_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [PIX_W-1:0]  req_pixel_x = '0;
   logic [PIX_W-1:0]  req_pixel_y = '0;
   logic signed [31:0] req_height_here = '0;
   logic signed [31:0] req_height_right = '0;
   logic signed [31:0] req_height_below = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PIX_W-1:0]  rsp_out_x;
   logic [PIX_W-1:0]  rsp_out_y;
   logic [7:0]        rsp_red;
   logic [7:0]        rsp_green;
   logic [7:0]        rsp_blue;
   logic [7:0]        rsp_alpha;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   logic signed [31:0] win_origin_x = ORIGIN_RESET;
   logic signed [31:0] win_origin_y = ORIGIN_RESET;
   logic [30:0]        win_step_x = STEP_RESET;
   logic [30:0]        win_step_y = STEP_RESET;
   logic [1:0]         shown_component = COMP_SEL_RESET;
   logic [31:0]        colour_low = LOW_COLOR_RESET;
   logic [31:0]        colour_high = HIGH_COLOR_RESET;

   shaded_pixel_type   pending_pixels [$];
   int                 mismatch_count = 0;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   int                 quiet_cycles = 0;

   height_normal_shader_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] value);
      logic [63:0] root;
      logic [63:0] bit_w;
      root = '0;
      bit_w = 64'd1 << 62;
      while (bit_w > value) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (value >= root + bit_w) begin
            value = value - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   function automatic shaded_pixel_type shade_pixel(logic [7:0] px, logic [7:0] py,
         logic signed [31:0] h, logic signed [31:0] hr, logic signed [31:0] hb);
      shaded_pixel_type   res;
      logic signed [127:0] pxw, pyw, sx, sy, hw, hrw, hbw, xc, yc, a, b, c;
      logic signed [127:0] det [4];
      logic [127:0]        wide_mag [4];
      logic [63:0]         mag [4];
      logic                negs [4];
      logic [63:0]         sum;
      logic [63:0]         root;
      longint              v;
      longint              n;
      int                  m;
      int                  bl;
      int unsigned         t;
      int unsigned         lo;
      int unsigned         hi;
      pxw = px;
      pyw = py;
      sx = win_step_x;
      sy = win_step_y;
      hw = h;
      hrw = hr;
      hbw = hb;
      xc = win_origin_x;
      yc = win_origin_y;
      xc = xc + pxw * sx;
      yc = yc + pyw * sy;
      a = -(sy * (hrw - hw));
      b = sx * (hbw - hw);
      c = sx * sy;
      det[0] = a * 65536;
      det[1] = b * 65536;
      det[2] = c * 65536;
      det[3] = xc * a - yc * b + hw * c;
      m = 0;
      for (int i = 0; i < 4; i++) begin
         negs[i] = det[i] < 0;
         wide_mag[i] = negs[i] ? -det[i] : det[i];
         bl = 0;
         for (int j = 0; j < 128; j++) if (wide_mag[i][j]) bl = j + 1;
         if (bl > m) m = bl;
      end
      n = 0;
      if (m > 0) begin
         sum = '0;
         for (int i = 0; i < 4; i++) begin
            if (m > NORM_BITS) mag[i] = 64'(wide_mag[i] >> (m - NORM_BITS));
            else mag[i] = 64'(wide_mag[i] << (NORM_BITS - m));
            sum = sum + mag[i] * mag[i];
         end
         root = floor_sqrt(sum);
         v = longint'(mag[shown_component]);
         if (negs[shown_component]) v = -v;
         n = (v * 32768) / longint'(root);
         if (n > 32767) n = 32767;
         if (n < -32768) n = -32768;
      end
      t = int'(32768 + n);
      res.x = px;
      res.y = py;
      for (int k = 0; k < 4; k++) begin
         lo = colour_low[8*k +: 8];
         hi = colour_high[8*k +: 8];
         res.ch[k] = 8'((lo * (65536 - t) + hi * t) >> 16);
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("Mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      shaded_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("Unexpected result transfer at %0t", $realtime);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_red !== want.ch[0]) report_mismatch("red", rsp_red, want.ch[0]);
            if (rsp_green !== want.ch[1]) report_mismatch("green", rsp_green, want.ch[1]);
            if (rsp_blue !== want.ch[2]) report_mismatch("blue", rsp_blue, want.ch[2]);
            if (rsp_alpha !== want.ch[3]) report_mismatch("alpha", rsp_alpha, want.ch[3]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(logic [7:0] px, logic [7:0] py,
         logic [31:0] h, logic [31:0] hr, logic [31:0] hb);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_height_here <= h;
      req_height_right <= hr;
      req_height_below <= hb;
      do @(posedge clock); while (req_stall);
      pending_pixels.push_back(shade_pixel(px, py, h, hr, hb));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ORIGIN_X:   win_origin_x = data;
         CSR_ORIGIN_Y:   win_origin_y = data;
         CSR_STEP_X:     win_step_x = data[30:0];
         CSR_STEP_Y:     win_step_y = data[30:0];
         CSR_COMP_SEL:   shown_component = data[1:0];
         CSR_LOW_COLOR:  colour_low = data;
         CSR_HIGH_COLOR: colour_high = data;
         default: ;
      endcase
   endtask

   task automatic set_window(logic [31:0] ox, logic [31:0] oy, logic [30:0] sx,
         logic [30:0] sy, logic [1:0] sel, logic [31:0] lo, logic [31:0] hi);
      wait_idle();
      write_register(CSR_ORIGIN_X, ox);
      write_register(CSR_ORIGIN_Y, oy);
      write_register(CSR_STEP_X, {1'b0, sx});
      write_register(CSR_STEP_Y, {1'b0, sy});
      write_register(CSR_COMP_SEL, {30'd0, sel});
      write_register(CSR_LOW_COLOR, lo);
      write_register(CSR_HIGH_COLOR, hi);
   endtask

   task automatic test_reset_defaults();
      send_pixel(8'd0, 8'd0, 32'd0, 32'd0, 32'd0);
      send_pixel(8'd100, 8'd100, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
      send_pixel(8'd255, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
   endtask

   task automatic test_field_extremes();
      for (int sel = 0; sel < 4; sel++) begin
         set_window(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, sel[1:0],
                    32'h0000_0000, 32'hFFFF_FFFF);
         send_pixel(8'd0, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
         send_pixel(8'd255, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
         send_pixel(8'd170, 8'd85, 32'h0003_0000, 32'h0001_0000, 32'h0005_0000);
         send_pixel(8'd85, 8'd170, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end
      set_window(32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 31'h7FFF_FFFF, 2'd3,
                 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(8'd255, 8'd255, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);
      send_pixel(8'd0, 8'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
   endtask

   task automatic test_zero_norm();
      set_window(32'h0001_0000, 32'hFFFF_0000, 31'd0, 31'd0, 2'd2,
                 32'h0102_0304, 32'hF0E0_D0C0);
      send_pixel(8'd12, 8'd34, 32'h0001_0000, 32'h0004_0000, 32'hFFF0_0000);
      send_pixel(8'd255, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      wait_idle();
      write_register(CSR_STEP_X, 32'd6554);
      send_pixel(8'd7, 8'd9, 32'h0002_0000, 32'h0002_0000, 32'h0003_0000);
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int count);
      logic [31:0] base;
      set_window($urandom, $urandom,
                 ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 20)),
                 ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 20)),
                 2'($urandom), $urandom, $urandom);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            req_valid <= 1'b0;
            wait (pending_pixels.size() == 0);
         end
         base = $urandom;
         if ($urandom_range(1)) begin
            send_pixel(8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
         end else begin
            send_pixel(8'($urandom), 8'($urandom), base,
                       base + $urandom_range(0, 1 << 18) - (1 << 17),
                       base + $urandom_range(0, 1 << 18) - (1 << 17));
         end
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_field_extremes();
      test_zero_norm();
      test_random_phase(0, 0, 100);
      test_random_phase(68, 0, 100);
      test_random_phase(0, 68, 100);
      test_random_phase(25, 25, 100);
      req_valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
